// ----- sv/lpq_pkg.sv -----
package lpq_pkg;

	localparam int DEPTH    = 16;
	localparam int KEY_BITS = 8;
	localparam int LEN_W    = 8;
	localparam int TAG_W    = 64;
	localparam int TOTAL_W  = 5;
	localparam int CNT_W    = $clog2(DEPTH + 1);

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef struct packed {
		key_t             key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t item;
	} cell_cmd_t;

	typedef struct packed {
		logic [LEN_W-1:0]   popped_length;
		logic [TAG_W-1:0]   popped_tag;
		logic               pop_valid;
		logic               empty_error;
		logic               full_error;
		logic [TOTAL_W-1:0] entry_total;
	} result_t;

	function automatic key_t len_to_key(input logic [LEN_W-1:0] len);
		logic [KEY_BITS+LEN_W-1:0] wide;
		wide = {{KEY_BITS{1'b0}}, len};
		return wide[KEY_BITS-1:0];
	endfunction

	function automatic logic [LEN_W-1:0] key_to_len(input key_t key);
		logic [KEY_BITS+LEN_W-1:0] wide;
		wide = {{LEN_W{1'b0}}, key};
		return wide[LEN_W-1:0];
	endfunction

endpackage

// ----- sv/lpq_req_if.sv -----
interface lpq_req_if;
	import lpq_pkg::*;

	logic             valid;
	logic             ready;
	logic             func;
	logic [LEN_W-1:0] word_length;
	logic [TAG_W-1:0] word_tag;

	modport source (output valid, output func, output word_length, output word_tag,
		input ready);
	modport sink (input valid, input func, input word_length, input word_tag,
		output ready);

endinterface

// ----- sv/lpq_rsp_if.sv -----
interface lpq_rsp_if;
	import lpq_pkg::*;

	logic               valid;
	logic               ready;
	logic [LEN_W-1:0]   popped_length;
	logic [TAG_W-1:0]   popped_tag;
	logic               pop_valid;
	logic               empty_error;
	logic               full_error;
	logic [TOTAL_W-1:0] entry_total;

	modport source (output valid, output popped_length, output popped_tag,
		output pop_valid, output empty_error, output full_error, output entry_total,
		input ready);
	modport sink (input valid, input popped_length, input popped_tag,
		input pop_valid, input empty_error, input full_error, input entry_total,
		output ready);

endinterface

// ----- sv/lpq_cell.sv -----
module lpq_cell (
	input  logic               clk,
	input  lpq_pkg::cell_cmd_t cmd,
	input  logic               occ,
	input  logic               prev_occ,
	input  logic               prev_disp,
	input  lpq_pkg::entry_t    prev_entry,
	input  lpq_pkg::entry_t    next_entry,
	output logic               disp,
	output lpq_pkg::entry_t    entry
);
	import lpq_pkg::*;

	entry_t entry_q;
	logic   take_new;

	// A held entry with a strictly larger key moves one place back on a push,
	// so equal keys stay in arrival order.
	assign disp     = occ && (entry_q.key > cmd.item.key);
	assign take_new = disp || (!occ && prev_occ);
	assign entry    = entry_q;

	// A cell that is neither shifted nor written keeps its entry.
	always_ff @(posedge clk) begin
		priority if (cmd.pop) begin
			entry_q <= next_entry;
		end else if (cmd.push) begin
			priority if (prev_disp) begin
				entry_q <= prev_entry;
			end else if (take_new) begin
				entry_q <= cmd.item;
			end else begin
				entry_q <= entry_q;
			end
		end else begin
			entry_q <= entry_q;
		end
	end

endmodule

// ----- sv/length_priority_queue_top.sv -----
// A result word is registered in the output buffer when its request word is accepted.
// One request word is accepted per cycle while the skid register is empty; every cell
// of the sorted chain compares and shifts in parallel for both push and pop.
// A two-word output buffer lets requests keep flowing while one result waits.
// Reset (arst_n, asynchronous, active low) empties the queue and the output buffer;
// the cell contents are not reset and cells beyond the entry count never reach the result.
module length_priority_queue_top (
	input  logic      clk,
	input  logic      arst_n,
	lpq_req_if.sink   req,
	lpq_rsp_if.source rsp
);
	import lpq_pkg::*;

	// Number of entries held; cells below this index are occupied, in sorted order
	// with the front (smallest key, oldest among equals) in cell zero.
	cnt_t count_q;
	cnt_t count_next;

	logic      accept;
	logic      is_full;
	logic      is_empty;
	cell_cmd_t cmd;
	result_t   res;

	logic   [DEPTH-1:0] occ;
	logic   [DEPTH-1:0] disp;
	entry_t             entries [DEPTH];

	// Output buffer: a main register and a skid register behind it.
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    drain;

	assign req.ready = !skid_valid_q;
	assign accept    = req.valid && req.ready;
	assign is_full   = (count_q == cnt_t'(DEPTH));
	assign is_empty  = (count_q == '0);

	// The command only reaches the cells when it really changes the queue:
	// a push into a full store and a pop of an empty one leave the cells alone.
	always_comb begin
		cmd.push     = accept && (req.func == FUNC_PUSH) && !is_full;
		cmd.pop      = accept && (req.func == FUNC_POP) && !is_empty;
		cmd.item.key = len_to_key(req.word_length);
		cmd.item.tag = req.word_tag;
	end

	always_comb begin
		count_next = count_q;
		if (cmd.push) begin
			count_next = count_q + cnt_t'(1);
		end else if (cmd.pop) begin
			count_next = count_q - cnt_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// The chain of cells. Each cell looks at its neighbor on either side: on a
	// push it takes the entry of the cell in front when that one is displaced,
	// on a pop it takes the entry of the cell behind it.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ[i] = (cnt_t'(i) < count_q);

		lpq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occ        (occ[i]),
			.prev_occ   ((i == 0) ? 1'b1 : occ[(i == 0) ? 0 : i - 1]),
			.prev_disp  ((i == 0) ? 1'b0 : disp[(i == 0) ? 0 : i - 1]),
			.prev_entry (entries[(i == 0) ? 0 : i - 1]),
			.next_entry (entries[(i == DEPTH - 1) ? i : i + 1]),
			.disp       (disp[i]),
			.entry      (entries[i])
		);
	end

	// Result of the accepted request, formed from the front cell and the count.
	always_comb begin
		res.popped_length = '0;
		res.popped_tag    = '0;
		res.pop_valid     = 1'b0;
		res.empty_error   = 1'b0;
		res.full_error    = 1'b0;
		res.entry_total   = count_next[TOTAL_W-1:0];
		if (req.func == FUNC_POP) begin
			if (is_empty) begin
				res.empty_error = 1'b1;
			end else begin
				res.popped_length = key_to_len(entries[0].key);
				res.popped_tag    = entries[0].tag;
				res.pop_valid     = 1'b1;
			end
		end else begin
			res.full_error = is_full;
		end
	end

	assign drain = out_valid_q && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (drain) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= accept;
				end
			end else if (accept) begin
				if (!out_valid_q) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	// Payload of the output buffer carries no reset.
	always_ff @(posedge clk) begin
		if (drain) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (accept) begin
			if (!out_valid_q) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.popped_length = out_q.popped_length;
	assign rsp.popped_tag    = out_q.popped_tag;
	assign rsp.pop_valid     = out_q.pop_valid;
	assign rsp.empty_error   = out_q.empty_error;
	assign rsp.full_error    = out_q.full_error;
	assign rsp.entry_total   = out_q.entry_total;

endmodule
